FILE: rtl/limit_order_matching_book_defines.svh
// Assertion macros for the limit order matching book.
// Used by the top level; no other dependencies.
`ifndef LIMIT_ORDER_MATCHING_BOOK_DEFINES_SVH
`define LIMIT_ORDER_MATCHING_BOOK_DEFINES_SVH

// Same-cycle implication, held off during reset
`define LOMB_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lomb assertion failed");

// Next-cycle implication, held off during reset
`define LOMB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lomb assertion failed");

`endif

FILE: rtl/lomb_pkg.sv
// Shared codes for the limit order matching book.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lomb_pkg;
    localparam logic CMD_BUY  = 1'b0;
    localparam logic CMD_SELL = 1'b1;
    localparam logic SIDE_BID = 1'b0;
    localparam logic SIDE_ASK = 1'b1;
    localparam int   PRICE_W  = 10;
    localparam int   VOL_W    = 32;
endpackage
`default_nettype wire

FILE: rtl/limit_order_matching_book.sv
// Limit order matching book: an order takes one pass of a small sequencer over two
// synchronous memories (level head/count, order volumes). The sequencer starts an order
// with a match check, reads the level and then the volume of each resting order it uses,
// steps level by level to find the new best price after a level empties, rests any
// remainder, and hands off the result, held there while the previous result waits; a new
// order is taken only while idle. After reset a clearing pass through all 2*PRICE_LEVELS
// entries of the level memory runs before the first item is taken.
// Depends on lomb_pkg and limit_order_matching_book_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "limit_order_matching_book_defines.svh"
module limit_order_matching_book
    import lomb_pkg::*;
#(
    parameter int PRICE_LEVELS = 1024,
    parameter int LEVEL_DEPTH  = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire logic [PRICE_W-1:0] limit_price,
    input  wire logic [VOL_W-1:0]   order_volume,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [VOL_W-1:0]        order_id,
    output logic [VOL_W-1:0]        filled_volume,
    output logic                    rejected,
    output logic [PRICE_W-1:0]      best_bid,
    output logic                    bid_valid,
    output logic [PRICE_W-1:0]      best_ask,
    output logic                    ask_valid
);
    localparam int LW   = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int DW   = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CW   = $clog2(LEVEL_DEPTH + 1);
    localparam int SW   = $clog2(PRICE_LEVELS * LEVEL_DEPTH);
    localparam int CMPW = (LW > PRICE_W) ? LW : PRICE_W;
    localparam int LMW  = DW + CW;

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_MCHK     = 4'd2;
    localparam logic [3:0] S_LVL      = 4'd3;
    localparam logic [3:0] S_VOL      = 4'd4;
    localparam logic [3:0] S_SCAN_RD  = 4'd5;
    localparam logic [3:0] S_SCAN_CHK = 4'd6;
    localparam logic [3:0] S_REST     = 4'd7;
    localparam logic [3:0] S_REST_LVL = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    typedef logic [LW-1:0] lvl_t;

    // memories
    logic [LMW-1:0]   lvl_mem [2*PRICE_LEVELS];
    logic [VOL_W-1:0] vol_mem [2*PRICE_LEVELS*LEVEL_DEPTH];
    logic [LW:0]      lvl_ra, lvl_wa;
    logic [LMW-1:0]   lvl_rdata, lvl_wdata;
    logic             lvl_we;
    logic [SW:0]      vol_ra, vol_wa;
    logic [VOL_W-1:0] vol_rdata, vol_wdata;
    logic             vol_we;

    always_ff @(posedge clk)
    begin
        if (lvl_we)
        begin
            lvl_mem[lvl_wa] <= lvl_wdata;
        end
        lvl_rdata <= lvl_mem[lvl_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vol_we)
        begin
            vol_mem[vol_wa] <= vol_wdata;
        end
        vol_rdata <= vol_mem[vol_ra];
    end

    // control and item registers
    logic [3:0]       state_reg, state_next;
    logic [LW:0]      clr_reg, clr_next;
    logic             side_reg, side_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic [VOL_W-1:0] rem_reg, rem_next;
    logic [VOL_W-1:0] filled_reg, filled_next;
    logic [VOL_W-1:0] cnt_reg, cnt_next;
    lvl_t             best_reg [2];
    lvl_t             best_next [2];
    logic [1:0]       bval_reg, bval_next;
    lvl_t             scan_reg, scan_next;
    logic [DW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic             out_valid_reg, out_valid_next;
    logic [VOL_W-1:0] id_reg, id_next;
    logic             rej_reg, rej_next;

    function automatic logic [SW-1:0] slot_of(lvl_t l, logic [DW-1:0] idx);
        slot_of = SW'(l) * SW'(LEVEL_DEPTH) + SW'(idx);
    endfunction

    // derived values
    logic             opp;
    lvl_t             opp_best;
    logic [CMPW-1:0]  opp_best_ext, price_ext;
    logic             price_ok, price_high;
    lvl_t             price_lvl;
    logic [DW-1:0]    rd_head;
    logic [CW-1:0]    rd_count;
    logic [DW-1:0]    head_inc;
    logic [DW+1:0]    tail_sum;
    logic [DW-1:0]    tail_idx;
    logic [CMPW-1:0]  bb_ext, ba_ext;

    assign opp          = ~side_reg;
    assign opp_best     = best_reg[opp];
    assign opp_best_ext = CMPW'(opp_best);
    assign price_ext    = CMPW'(price_reg);
    assign price_lvl    = price_ext[LW-1:0];
    assign price_high   = ({1'b0, price_ext} >= (CMPW+1)'(PRICE_LEVELS));
    // a buy takes asks at or below its limit, a sell takes bids at or above
    assign price_ok     = (opp == SIDE_ASK) ? (opp_best_ext <= price_ext)
                                            : (opp_best_ext >= price_ext);
    assign rd_head      = lvl_rdata[LMW-1:CW];
    assign rd_count     = lvl_rdata[CW-1:0];
    assign head_inc     = (head_reg == DW'(LEVEL_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum     = (DW+2)'(rd_head) + (DW+2)'(rd_count);
    assign tail_idx     = (tail_sum >= (DW+2)'(LEVEL_DEPTH))
                          ? DW'(tail_sum - (DW+2)'(LEVEL_DEPTH)) : tail_sum[DW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        side_next      = side_reg;
        price_next     = price_reg;
        rem_next       = rem_reg;
        filled_next    = filled_reg;
        cnt_next       = cnt_reg;
        best_next[0]   = best_reg[0];
        best_next[1]   = best_reg[1];
        bval_next      = bval_reg;
        scan_next      = scan_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        id_next        = id_reg;
        rej_next       = rej_reg;
        lvl_ra         = {opp, opp_best};
        lvl_we         = 1'b0;
        lvl_wa         = {opp, opp_best};
        lvl_wdata      = '0;
        vol_ra         = {opp, slot_of(opp_best, rd_head)};
        vol_we         = 1'b0;
        vol_wa         = {opp, slot_reg};
        vol_wdata      = vol_rdata - rem_reg;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                lvl_we    = 1'b1;
                lvl_wa    = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == (LW+1)'(2*PRICE_LEVELS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    side_next   = cmd;
                    price_next  = limit_price;
                    rem_next    = order_volume;
                    filled_next = '0;
                    state_next  = S_MCHK;
                end
            end
            S_MCHK:
            begin
                // read the best opposite level, issued regardless
                if (rem_reg == '0 || !bval_reg[opp] || !price_ok)
                begin
                    state_next = S_REST;
                end
                else
                begin
                    state_next = S_LVL;
                end
            end
            S_LVL:
            begin
                head_next  = rd_head;
                count_next = rd_count;
                slot_next  = slot_of(opp_best, rd_head);
                state_next = S_VOL;
            end
            S_VOL:
            begin
                if (vol_rdata > rem_reg)
                begin
                    vol_we      = 1'b1;
                    filled_next = filled_reg + rem_reg;
                    rem_next    = '0;
                    state_next  = S_REST;
                end
                else
                begin
                    rem_next    = rem_reg - vol_rdata;
                    filled_next = filled_reg + vol_rdata;
                    lvl_we      = 1'b1;
                    lvl_wdata   = {head_inc, count_reg - 1'b1};
                    state_next  = S_MCHK;
                    if (count_reg == CW'(1))
                    begin
                        // level emptied: search for the next occupied one
                        if ((opp == SIDE_BID && opp_best == '0) ||
                            (opp == SIDE_ASK && opp_best == LW'(PRICE_LEVELS - 1)))
                        begin
                            bval_next[opp] = 1'b0;
                        end
                        else
                        begin
                            scan_next  = (opp == SIDE_BID) ? opp_best - 1'b1
                                                           : opp_best + 1'b1;
                            state_next = S_SCAN_RD;
                        end
                    end
                end
            end
            S_SCAN_RD:
            begin
                lvl_ra     = {opp, scan_reg};
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (rd_count != '0)
                begin
                    best_next[opp] = scan_reg;
                    state_next     = S_MCHK;
                end
                else if ((opp == SIDE_BID && scan_reg == '0) ||
                         (opp == SIDE_ASK && scan_reg == LW'(PRICE_LEVELS - 1)))
                begin
                    bval_next[opp] = 1'b0;
                    state_next     = S_MCHK;
                end
                else
                begin
                    scan_next  = (opp == SIDE_BID) ? scan_reg - 1'b1 : scan_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_REST:
            begin
                lvl_ra   = {side_reg, price_lvl};
                id_next  = '0;
                rej_next = 1'b0;
                if (rem_reg == '0)
                begin
                    state_next = S_OUT;
                end
                else if (price_high)
                begin
                    rej_next   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_REST_LVL;
                end
            end
            S_REST_LVL:
            begin
                if (CW'(rd_count) >= CW'(LEVEL_DEPTH))
                begin
                    rej_next = 1'b1;
                end
                else
                begin
                    vol_we    = 1'b1;
                    vol_wa    = {side_reg, slot_of(price_lvl, tail_idx)};
                    vol_wdata = rem_reg;
                    lvl_we    = 1'b1;
                    lvl_wa    = {side_reg, price_lvl};
                    lvl_wdata = {rd_head, rd_count + 1'b1};
                    cnt_next  = cnt_reg + 1'b1;
                    id_next   = cnt_reg + 1'b1;
                    if (!bval_reg[side_reg] ||
                        (side_reg == SIDE_BID && price_lvl > best_reg[side_reg]) ||
                        (side_reg == SIDE_ASK && price_lvl < best_reg[side_reg]))
                    begin
                        best_next[side_reg] = price_lvl;
                        bval_next[side_reg] = 1'b1;
                    end
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            bval_reg      <= '0;
            best_reg[0]   <= '0;
            best_reg[1]   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            bval_reg      <= bval_next;
            best_reg[0]   <= best_next[0];
            best_reg[1]   <= best_next[1];
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg   <= side_next;
        price_reg  <= price_next;
        rem_reg    <= rem_next;
        filled_reg <= filled_next;
        scan_reg   <= scan_next;
        head_reg   <= head_next;
        count_reg  <= count_next;
        slot_reg   <= slot_next;
        id_reg     <= id_next;
        rej_reg    <= rej_next;
    end

    // result register: loaded on leaving S_OUT
    logic [VOL_W-1:0]   res_id_reg, res_filled_reg;
    logic               res_rej_reg, res_bv_reg, res_av_reg;
    logic [PRICE_W-1:0] res_bb_reg, res_ba_reg;

    assign bb_ext = CMPW'(best_reg[SIDE_BID]);
    assign ba_ext = CMPW'(best_reg[SIDE_ASK]);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!out_valid_reg || out_ready))
        begin
            res_id_reg     <= id_reg;
            res_filled_reg <= filled_reg;
            res_rej_reg    <= rej_reg;
            res_bv_reg     <= bval_reg[SIDE_BID];
            res_av_reg     <= bval_reg[SIDE_ASK];
            res_bb_reg     <= bval_reg[SIDE_BID] ? bb_ext[PRICE_W-1:0] : '0;
            res_ba_reg     <= bval_reg[SIDE_ASK] ? ba_ext[PRICE_W-1:0] : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign order_id      = res_id_reg;
    assign filled_volume = res_filled_reg;
    assign rejected      = res_rej_reg;
    assign best_bid      = res_bb_reg;
    assign bid_valid     = res_bv_reg;
    assign best_ask      = res_ba_reg;
    assign ask_valid     = res_av_reg;

    `LOMB_ASSERT_NEXT(a_fill_grows, clk, rst_n, state_reg == S_VOL,
        filled_reg >= $past(filled_reg))
    `LOMB_ASSERT_NOW(a_rej_no_id, clk, rst_n, out_valid_reg && res_rej_reg,
        res_id_reg == '0)
    `LOMB_ASSERT_NOW(a_fill_nonempty, clk, rst_n, state_reg == S_VOL,
        count_reg != '0)

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for limit_order_matching_book: random and directed buy/sell
// orders, a behavioral price-time priority book as predictor, per-field result checks.
// Depends on lomb_pkg and the limit_order_matching_book RTL.
`timescale 1ns / 1ps
module testbench;
    import lomb_pkg::*;

    localparam int LEVELS = 1024;
    localparam int DEPTH  = 16;
    localparam int MAX_CYCLES = 10000000;

    typedef struct packed {
        logic               side;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   qty;
    } order_t;

    typedef struct packed {
        logic [VOL_W-1:0]   id;
        logic [VOL_W-1:0]   fill;
        logic               rej;
        logic [PRICE_W-1:0] bid;
        logic               bid_ok;
        logic [PRICE_W-1:0] ask;
        logic               ask_ok;
    } fill_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic cmd = CMD_BUY;
    logic [PRICE_W-1:0] limit_price = '0;
    logic [VOL_W-1:0] order_volume = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [VOL_W-1:0] order_id;
    logic [VOL_W-1:0] filled_volume;
    logic rejected;
    logic [PRICE_W-1:0] best_bid;
    logic bid_valid;
    logic [PRICE_W-1:0] best_ask;
    logic ask_valid;

    limit_order_matching_book uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .limit_price(limit_price), .order_volume(order_volume),
        .out_valid(out_valid), .out_ready(out_ready), .order_id(order_id),
        .filled_volume(filled_volume), .rejected(rejected), .best_bid(best_bid),
        .bid_valid(bid_valid), .best_ask(best_ask), .ask_valid(ask_valid)
    );

    // Predictor book state
    logic [VOL_W-1:0] bid_qty [LEVELS*DEPTH];
    logic [VOL_W-1:0] ask_qty [LEVELS*DEPTH];
    int unsigned bid_head [LEVELS];
    int unsigned bid_cnt [LEVELS];
    int unsigned ask_head [LEVELS];
    int unsigned ask_cnt [LEVELS];
    logic [VOL_W-1:0] next_id;

    order_t pending_orders[$];
    fill_report_t expected_reports[$];
    int errors = 0;
    int checked = 0;
    int fills_seen = 0;
    int rejects_seen = 0;
    int unsigned send_idle = 0;
    int unsigned recv_stall = 0;
    bit hold_off = 0;
    longint cycle = 0;

    function automatic bit find_best(input bit is_bid, output int unsigned lvl);
        int unsigned p;
        for (int i = 0; i < LEVELS; i++) begin
            p = is_bid ? LEVELS - 1 - i : i;
            if ((is_bid ? bid_cnt[p] : ask_cnt[p]) != 0) begin
                lvl = p;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic fill_report_t apply_order(input order_t o);
        fill_report_t r;
        logic [VOL_W-1:0] rest;
        logic [VOL_W-1:0] v;
        int unsigned lvl;
        int unsigned slot;
        bit hit_bids;
        r = '0;
        rest = o.qty;
        hit_bids = (o.side == CMD_SELL);
        while (rest != 0 && find_best(hit_bids, lvl)) begin
            if (hit_bids ? (lvl < o.price) : (lvl > o.price))
                break;
            if (hit_bids)
            begin
                slot = lvl * DEPTH + bid_head[lvl];
                v = bid_qty[slot];
            end
            else
            begin
                slot = lvl * DEPTH + ask_head[lvl];
                v = ask_qty[slot];
            end
            if (v > rest) begin
                if (hit_bids) bid_qty[slot] = v - rest;
                else ask_qty[slot] = v - rest;
                r.fill += rest;
                rest = 0;
            end else begin
                rest -= v;
                r.fill += v;
                if (hit_bids) begin
                    bid_head[lvl] = (bid_head[lvl] + 1) % DEPTH;
                    bid_cnt[lvl]--;
                end else begin
                    ask_head[lvl] = (ask_head[lvl] + 1) % DEPTH;
                    ask_cnt[lvl]--;
                end
            end
        end
        if (rest != 0) begin
            if (o.side == CMD_SELL && ask_cnt[o.price] < DEPTH) begin
                ask_qty[o.price * DEPTH + (ask_head[o.price] + ask_cnt[o.price]) % DEPTH] = rest;
                ask_cnt[o.price]++;
                next_id++;
                r.id = next_id;
            end else if (o.side == CMD_BUY && bid_cnt[o.price] < DEPTH) begin
                bid_qty[o.price * DEPTH + (bid_head[o.price] + bid_cnt[o.price]) % DEPTH] = rest;
                bid_cnt[o.price]++;
                next_id++;
                r.id = next_id;
            end else begin
                r.rej = 1'b1;
            end
        end
        r.bid_ok = find_best(1, lvl);
        if (r.bid_ok) r.bid = lvl[PRICE_W-1:0];
        r.ask_ok = find_best(0, lvl);
        if (r.ask_ok) r.ask = lvl[PRICE_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [VOL_W-1:0] got,
                                   input logic [VOL_W-1:0] want);
        $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle, what, got, want);
        errors++;
    endtask

    function automatic order_t make_order(input logic side, input int unsigned price,
                                          input logic [VOL_W-1:0] qty);
        order_t o;
        o.side = side;
        o.price = price[PRICE_W-1:0];
        o.qty = qty;
        return o;
    endfunction

    // append one order to the driver's queue
    function automatic void add_order(input order_t o);
        pending_orders = {pending_orders, o};
    endfunction

    function automatic logic [VOL_W-1:0] random_qty();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            3: return 32'h8000_0000 | $urandom_range(0, 255);
            default: return $urandom_range(1, 300);
        endcase
    endfunction

    initial begin
        forever #6 clk = ~clk;
    end

    // Driver: hold each item until accepted
    always @(posedge clk) begin
        order_t o;
        cycle <= cycle + 1;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                expected_reports = {expected_reports, apply_order(pending_orders[0])};
                pending_orders.delete(0);
            end
            if (!in_valid || in_ready) begin
                if (pending_orders.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
                    o = pending_orders[0];
                    in_valid <= 1'b1;
                    cmd <= o.side;
                    limit_price <= o.price;
                    order_volume <= o.qty;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expectation
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("result with none expected", '0, '0);
                end else begin
                    fill_report_t e;
                    e = expected_reports[0];
                    expected_reports.delete(0);
                    checked++;
                    if (filled_volume != 0) fills_seen++;
                    if (rejected) rejects_seen++;
                    if (order_id !== e.id) report_mismatch("order_id", order_id, e.id);
                    if (filled_volume !== e.fill)
                        report_mismatch("filled_volume", filled_volume, e.fill);
                    if (rejected !== e.rej)
                        report_mismatch("rejected", VOL_W'(rejected), VOL_W'(e.rej));
                    if (best_bid !== e.bid)
                        report_mismatch("best_bid", VOL_W'(best_bid), VOL_W'(e.bid));
                    if (bid_valid !== e.bid_ok)
                        report_mismatch("bid_valid", VOL_W'(bid_valid), VOL_W'(e.bid_ok));
                    if (best_ask !== e.ask)
                        report_mismatch("best_ask", VOL_W'(best_ask), VOL_W'(e.ask));
                    if (ask_valid !== e.ask_ok)
                        report_mismatch("ask_valid", VOL_W'(ask_valid), VOL_W'(e.ask_ok));
                end
            end
            out_ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall);
        end
    end

    // Long receiver hold-off so the block backs up into its input
    initial begin
        int unsigned held;
        wait (rst_n);
        // start once the block has finished its clearing pass and takes items
        @(posedge clk);
        while (!(in_valid && in_ready)) @(posedge clk);
        hold_off <= 1'b1;
        held = 0;
        while (held < 400) begin
            @(posedge clk);
            held++;
        end
        hold_off <= 1'b0;
    end

    initial begin
        if (cycle >= 0) begin
            wait (cycle >= MAX_CYCLES);
            $display("Timeout after %0d cycles", cycle);
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic run_phase(input int unsigned n, input int unsigned s_idle,
                             input int unsigned r_stall);
        send_idle = s_idle;
        recv_stall = r_stall;
        for (int i = 0; i < n; i++) begin
            int unsigned k;
            logic side;
            int unsigned base;
            k = $urandom_range(0, 19);
            side = 1'($urandom_range(0, 1));
            base = 500 + $urandom_range(0, 24);
            if (k == 0)
                add_order(make_order(side, $urandom_range(0, LEVELS-1), random_qty()));
            else if (k == 1)
                // pile onto one level to overfill it
                add_order(make_order(side, side ? 700 : 300, $urandom_range(1, 50)));
            else
                add_order(make_order(side, base, random_qty()));
        end
        wait (pending_orders.size() == 0 && expected_reports.size() == 0);
    endtask

    initial begin
        int unsigned tail;
        for (int i = 0; i < LEVELS; i++) begin
            bid_head[i] = 0; bid_cnt[i] = 0; ask_head[i] = 0; ask_cnt[i] = 0;
        end
        next_id = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, both sides, zero volume, full level
        send_idle = 0;
        recv_stall = 0;
        add_order(make_order(CMD_BUY, 0, 0));
        add_order(make_order(CMD_BUY, 0, 32'hFFFF_FFFF));
        add_order(make_order(CMD_SELL, 1023, 32'hFFFF_FFFF));
        add_order(make_order(CMD_SELL, 0, 32'h5555_5555));
        add_order(make_order(CMD_BUY, 1023, 32'hAAAA_AAAA));
        add_order(make_order(CMD_BUY, 1023, 32'hFFFF_FFFF));
        for (int i = 0; i < 17; i++)
            add_order(make_order(CMD_SELL, 1023, i + 1));
        add_order(make_order(CMD_BUY, 1023, 40));
        add_order(make_order(CMD_SELL, 0, 32'hFFFF_FFFF));
        wait (pending_orders.size() == 0 && expected_reports.size() == 0);

        run_phase(140, 0, 0);
        run_phase(140, 85, 0);
        run_phase(140, 0, 85);
        run_phase(110, 8, 8);

        tail = 0;
        while (tail < 5000) begin
            @(posedge clk);
            tail++;
        end
        $display("Checked %0d results: %0d with fills, %0d rejected remainders.",
                 checked, fills_seen, rejects_seen);
        if (errors == 0 && expected_reports.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

FILE: limit_order_matching_book.f
+incdir+rtl
rtl/lomb_pkg.sv
rtl/limit_order_matching_book.sv
tb/testbench.sv
